// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros. Every user module has clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent holds at the next edge
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tbr_pkg.sv =====
// ----------------------------------------------------------------------------
// tbr_pkg
// Shared constants and register codes of the triangle bounding-box rasterizer.
// ----------------------------------------------------------------------------
package tbr_pkg;

    // Default vertex coordinate width
    localparam int COORD_BITS_DEF = 12;

    // Vertex register file
    localparam int NUM_REGS = 6;
    localparam int CFG_IDX_BITS = 3;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_A_X = 3'd0,
        REG_A_Y = 3'd1,
        REG_B_X = 3'd2,
        REG_B_Y = 3'd3,
        REG_C_X = 3'd4,
        REG_C_Y = 3'd5
    } tbr_reg_t;

endpackage

// ===== hw/rtl/triangle_bbox_rasterizer_core.sv =====
// ----------------------------------------------------------------------------
// triangle_bbox_rasterizer_core
// Walks the bounding box of a configured triangle and flags covered positions.
// ----------------------------------------------------------------------------
// Usage:
//   Vertices are written on the cfg port (cfg_we, cfg_index, cfg_data) while
//   no request is in flight. Each request on the input channel (in_valid,
//   in_stall, restart) yields exactly one result on the output channel
//   (out_valid, out_stall, pixel_x, pixel_y, covered, last).
//   restart=1 jumps to the box corner (min x, min y); restart=0 steps to the
//   next position: y fastest, then x. After (max x, max y), flagged by last,
//   the walk wraps to the corner. A stored position outside the current box
//   also restarts at the corner.
//   Each request passes the position register, the product register and the
//   output register, which takes the edge sums and sign test. One request per
//   cycle is sustained while out_stall is low. Reset clears the vertices to
//   zero and makes the first request emit the corner. While out_stall holds,
//   the result stays put; up to three requests are buffered before in_stall
//   rises.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module triangle_bbox_rasterizer_core #(
    parameter int COORD_BITS = tbr_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [tbr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [COORD_BITS-1:0]             cfg_data,
    // request channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              restart,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [COORD_BITS-1:0]      pixel_x,
    output logic signed [COORD_BITS-1:0]      pixel_y,
    output logic                              covered,
    output logic                              last
);

    logic [tbr_pkg::NUM_REGS-1:0][COORD_BITS-1:0] vtx_reg;

    logic signed [COORD_BITS-1:0] scan_x_reg, scan_y_reg;
    logic                         at_start_reg;

    logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy;
    logic signed [COORD_BITS-1:0] lo_x, hi_x, lo_y, hi_y;
    logic signed [COORD_BITS-1:0] px_next, py_next;
    logic                         inside_box, jump, last_next, accept;

    assign ax = vtx_reg[tbr_pkg::REG_A_X];
    assign ay = vtx_reg[tbr_pkg::REG_A_Y];
    assign bx = vtx_reg[tbr_pkg::REG_B_X];
    assign by = vtx_reg[tbr_pkg::REG_B_Y];
    assign cx = vtx_reg[tbr_pkg::REG_C_X];
    assign cy = vtx_reg[tbr_pkg::REG_C_Y];

    assign accept = in_valid && !in_stall;

    // Vertex register writes; unused indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtx_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (tbr_pkg::tbr_reg_t'(cfg_index))
                tbr_pkg::REG_A_X: vtx_reg[tbr_pkg::REG_A_X] <= cfg_data;
                tbr_pkg::REG_A_Y: vtx_reg[tbr_pkg::REG_A_Y] <= cfg_data;
                tbr_pkg::REG_B_X: vtx_reg[tbr_pkg::REG_B_X] <= cfg_data;
                tbr_pkg::REG_B_Y: vtx_reg[tbr_pkg::REG_B_Y] <= cfg_data;
                tbr_pkg::REG_C_X: vtx_reg[tbr_pkg::REG_C_X] <= cfg_data;
                tbr_pkg::REG_C_Y: vtx_reg[tbr_pkg::REG_C_Y] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Bounding box
    always_comb
    begin
        lo_x = ax;
        hi_x = ax;
        lo_y = ay;
        hi_y = ay;
        if (bx < lo_x) lo_x = bx;
        if (cx < lo_x) lo_x = cx;
        if (bx > hi_x) hi_x = bx;
        if (cx > hi_x) hi_x = cx;
        if (by < lo_y) lo_y = by;
        if (cy < lo_y) lo_y = cy;
        if (by > hi_y) hi_y = by;
        if (cy > hi_y) hi_y = cy;
    end

    // Next scan position
    always_comb
    begin
        inside_box = (scan_x_reg >= lo_x) && (scan_x_reg <= hi_x)
                  && (scan_y_reg >= lo_y) && (scan_y_reg <= hi_y);
        jump = restart || at_start_reg || !inside_box
            || ((scan_x_reg == hi_x) && (scan_y_reg == hi_y));
        priority if (jump)
        begin
            px_next = lo_x;
            py_next = lo_y;
        end
        else if (scan_y_reg < hi_y)
        begin
            px_next = scan_x_reg;
            py_next = scan_y_reg + COORD_BITS'(1);
        end
        else
        begin
            px_next = scan_x_reg + COORD_BITS'(1);
            py_next = lo_y;
        end
        last_next = (px_next == hi_x) && (py_next == hi_y);
    end

    // Scan state advances on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_x_reg   <= '0;
            scan_y_reg   <= '0;
            at_start_reg <= 1'b1;
        end
        else if (accept)
        begin
            scan_x_reg   <= px_next;
            scan_y_reg   <= py_next;
            at_start_reg <= 1'b0;
        end
    end

    // Coverage pipeline and output register
    tbr_coverage #(
        .COORD_BITS (COORD_BITS)
    ) u_coverage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pos_x     (px_next),
        .pos_y     (py_next),
        .pos_last  (last_next),
        .vtx       (vtx_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .covered   (covered),
        .last      (last)
    );

    // Checks
    `ASSERT_NEXT(a_restart_corner, accept && restart, (scan_x_reg == $past(lo_x)) && (scan_y_reg == $past(lo_y)), "restart missed corner")
    `ASSERT_NEXT(a_start_cleared, accept, !at_start_reg, "start flag stuck")

endmodule

// ===== hw/rtl/tbr_coverage.sv =====
// ----------------------------------------------------------------------------
// tbr_coverage
// Edge-function pipeline: position register, product stage, then
// sum and sign test into the output register. Valid/stall on both sides.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tbr_coverage #(
    parameter int COORD_BITS = tbr_pkg::COORD_BITS_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    // position side
    input  logic                                         in_valid,
    output logic                                         in_stall,
    input  logic signed [COORD_BITS-1:0]                 pos_x,
    input  logic signed [COORD_BITS-1:0]                 pos_y,
    input  logic                                         pos_last,
    // vertex registers, indexed by tbr_reg_t
    input  logic [tbr_pkg::NUM_REGS-1:0][COORD_BITS-1:0] vtx,
    // result side
    output logic                                         out_valid,
    input  logic                                         out_stall,
    output logic signed [COORD_BITS-1:0]                 pixel_x,
    output logic signed [COORD_BITS-1:0]                 pixel_y,
    output logic                                         covered,
    output logic                                         last
);

    localparam int DW = COORD_BITS + 1;        // coordinate difference
    localparam int PW = 2 * COORD_BITS + 2;    // product
    localparam int SW = 2 * COORD_BITS + 4;    // edge sums

    logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy;

    // stage 1: position
    logic                         s1_valid_reg;
    logic signed [COORD_BITS-1:0] s1_x_reg, s1_y_reg;
    logic                         s1_last_reg;

    // stage 2: products
    logic                         s2_valid_reg;
    logic signed [COORD_BITS-1:0] s2_x_reg, s2_y_reg;
    logic                         s2_last_reg;
    logic signed [PW-1:0]         m0_reg, m1_reg, m2_reg, m3_reg, m4_reg, m5_reg;

    // output register
    logic                         out_valid_reg;
    logic signed [COORD_BITS-1:0] out_x_reg, out_y_reg;
    logic                         out_cov_reg, out_last_reg;

    logic rdy_o, rdy_2, rdy_1;

    logic signed [DW-1:0] d_bax, d_cay, d_cax, d_bay, d_acx, d_acy;
    logic signed [DW-1:0] d_pxc, d_pyc, d_pxa, d_pya;
    logic signed [PW-1:0] m0_next, m1_next, m2_next, m3_next, m4_next, m5_next;

    logic signed [SW-1:0] area, beta, gamma, alpha;
    logic                 area_pos, area_nz, cov_next;

    assign ax = vtx[tbr_pkg::REG_A_X];
    assign ay = vtx[tbr_pkg::REG_A_Y];
    assign bx = vtx[tbr_pkg::REG_B_X];
    assign by = vtx[tbr_pkg::REG_B_Y];
    assign cx = vtx[tbr_pkg::REG_C_X];
    assign cy = vtx[tbr_pkg::REG_C_Y];

    // Stage readiness: a stage takes a request when empty or draining
    assign rdy_o    = !out_valid_reg || !out_stall;
    assign rdy_2    = !s2_valid_reg || rdy_o;
    assign rdy_1    = !s1_valid_reg || rdy_2;
    assign in_stall = !rdy_1;

    // Coordinate differences, one bit wider than the coordinates
    always_comb
    begin
        d_bax = DW'(bx) - DW'(ax);
        d_cay = DW'(cy) - DW'(ay);
        d_cax = DW'(cx) - DW'(ax);
        d_bay = DW'(by) - DW'(ay);
        d_acx = DW'(ax) - DW'(cx);
        d_acy = DW'(ay) - DW'(cy);
        d_pxc = DW'(s1_x_reg) - DW'(cx);
        d_pyc = DW'(s1_y_reg) - DW'(cy);
        d_pxa = DW'(s1_x_reg) - DW'(ax);
        d_pya = DW'(s1_y_reg) - DW'(ay);
    end

    // Six independent products
    always_comb
    begin
        m0_next = d_bax * d_cay;    // area terms
        m1_next = d_cax * d_bay;
        m2_next = d_acx * d_pyc;    // beta terms
        m3_next = d_pxc * d_acy;
        m4_next = d_bax * d_pya;    // gamma terms
        m5_next = d_pxa * d_bay;
    end

    // Edge sums and barycentric sign test; zero counts as inside
    always_comb
    begin
        area     = SW'(m0_reg) - SW'(m1_reg);
        beta     = SW'(m2_reg) - SW'(m3_reg);
        gamma    = SW'(m4_reg) - SW'(m5_reg);
        alpha    = area - beta - gamma;
        area_nz  = (area != '0);
        area_pos = area_nz && !area[SW-1];
        if (area_pos)
        begin
            cov_next = !beta[SW-1] && !gamma[SW-1] && !alpha[SW-1];
        end
        else
        begin
            cov_next = area_nz
                && (beta[SW-1] || beta == '0)
                && (gamma[SW-1] || gamma == '0)
                && (alpha[SW-1] || alpha == '0);
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy_1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (rdy_2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy_o)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (rdy_1 && in_valid)
        begin
            s1_x_reg    <= pos_x;
            s1_y_reg    <= pos_y;
            s1_last_reg <= pos_last;
        end
        if (rdy_2 && s1_valid_reg)
        begin
            s2_x_reg    <= s1_x_reg;
            s2_y_reg    <= s1_y_reg;
            s2_last_reg <= s1_last_reg;
            m0_reg      <= m0_next;
            m1_reg      <= m1_next;
            m2_reg      <= m2_next;
            m3_reg      <= m3_next;
            m4_reg      <= m4_next;
            m5_reg      <= m5_next;
        end
        if (rdy_o && s2_valid_reg)
        begin
            out_x_reg    <= s2_x_reg;
            out_y_reg    <= s2_y_reg;
            out_cov_reg  <= cov_next;
            out_last_reg <= s2_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_x   = out_x_reg;
    assign pixel_y   = out_y_reg;
    assign covered   = out_cov_reg;
    assign last      = out_last_reg;

    // Checks
    `ASSERT_NEXT(a_accept_fills_s1, in_valid && !in_stall, s1_valid_reg, "accepted request lost")
    `ASSERT_ALWAYS(a_out_from_s2, $rose(out_valid_reg) |-> $past(s2_valid_reg), "result from nothing")

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for triangle_bbox_rasterizer_core. Vertices go in over
// the cfg port while the core is idle. A request stream with random bursts
// and gaps drives the core, and the result side stalls at random. Each
// result is compared field by field with a local bounding-box walk and
// integer edge-function coverage test. Directed cases come first, then
// random triangles.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS    = tbr_pkg::COORD_BITS_DEF;
    localparam int RANDOM_ITEMS  = 850;
    localparam int DRAIN_CYCLES  = 8;

    // Indexes past the register file; writes there must be ignored
    localparam logic [tbr_pkg::CFG_IDX_BITS-1:0] SPARE_INDEX_LO =
        tbr_pkg::CFG_IDX_BITS'(tbr_pkg::NUM_REGS);
    localparam logic [tbr_pkg::CFG_IDX_BITS-1:0] SPARE_INDEX_HI =
        tbr_pkg::CFG_IDX_BITS'(tbr_pkg::NUM_REGS + 1);

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

    typedef struct {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         covered;
        logic                         last;
    } pixel_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_we = 1'b0;
    logic [tbr_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [COORD_BITS-1:0]             cfg_data = '0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic                              restart = 1'b0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic signed [COORD_BITS-1:0]      pixel_x;
    logic signed [COORD_BITS-1:0]      pixel_y;
    logic                              covered;
    logic                              last;

    // Local copy of the vertex registers and the walk position
    logic signed [COORD_BITS-1:0] vtx [tbr_pkg::NUM_REGS];
    longint walk_x;
    longint walk_y;
    bit     walk_at_start;

    pixel_t expected_pixels [$];

    int fail_count    = 0;
    int sent_count    = 0;
    int checked_count = 0;
    int covered_seen  = 0;
    int last_seen     = 0;
    int restart_count = 0;
    int phase_count   = 0;

    // Sender burst shaping
    int burst_left = 0;
    bit gaps_on    = 1'b1;

    // Receiver stall pattern
    stall_mode_t stall_mode = STALL_NONE;
    int          stall_hold = 0;

    triangle_bbox_rasterizer_core #(
        .COORD_BITS(COORD_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .covered   (covered),
        .last      (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Edge-function side test: zero counts as inside
    function automatic bit side_ok(input longint v, input longint area);
        return (area > 0) ? (v >= 0) : (v <= 0);
    endfunction

    // Next box position for one request, with its coverage and end flags
    function automatic pixel_t advance_walk(input bit restart_req);
        longint ax, ay, bx, by, cx, cy;
        longint lo_x, hi_x, lo_y, hi_y;
        longint px, py, area, beta, gamma, alpha;
        bit     in_box;
        pixel_t p;
        ax = vtx[tbr_pkg::REG_A_X];
        ay = vtx[tbr_pkg::REG_A_Y];
        bx = vtx[tbr_pkg::REG_B_X];
        by = vtx[tbr_pkg::REG_B_Y];
        cx = vtx[tbr_pkg::REG_C_X];
        cy = vtx[tbr_pkg::REG_C_Y];
        lo_x = (ax < bx) ? ax : bx;
        lo_x = (cx < lo_x) ? cx : lo_x;
        hi_x = (ax > bx) ? ax : bx;
        hi_x = (cx > hi_x) ? cx : hi_x;
        lo_y = (ay < by) ? ay : by;
        lo_y = (cy < lo_y) ? cy : lo_y;
        hi_y = (ay > by) ? ay : by;
        hi_y = (cy > hi_y) ? cy : hi_y;
        in_box = walk_x >= lo_x && walk_x <= hi_x && walk_y >= lo_y && walk_y <= hi_y;

        // Jump to the corner, step down the column, or move to the next one
        if (restart_req || walk_at_start || !in_box || (walk_x == hi_x && walk_y == hi_y))
        begin
            px = lo_x;
            py = lo_y;
        end
        else if (walk_y < hi_y)
        begin
            px = walk_x;
            py = walk_y + 1;
        end
        else
        begin
            px = walk_x + 1;
            py = lo_y;
        end

        area  = (bx - ax) * (cy - ay) - (cx - ax) * (by - ay);
        beta  = (ax - cx) * (py - cy) - (px - cx) * (ay - cy);
        gamma = (bx - ax) * (py - ay) - (px - ax) * (by - ay);
        alpha = area - beta - gamma;

        walk_x = px;
        walk_y = py;
        walk_at_start = 1'b0;

        p.x = px[COORD_BITS-1:0];
        p.y = py[COORD_BITS-1:0];
        p.covered = area != 0 && side_ok(beta, area) && side_ok(gamma, area) &&
                    side_ok(alpha, area);
        p.last = (px == hi_x && py == hi_y);
        return p;
    endfunction

    // One request; valid stays high afterwards so bursts run back to back
    task automatic send_request(input bit restart_req);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            if (gaps_on && $urandom_range(0, 1) == 1)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        restart  <= restart_req;
        do
            @(posedge clk);
        while (in_stall);
        expected_pixels.push_back(advance_walk(restart_req));
        sent_count++;
        restart_count += restart_req;
    endtask

    // Stop requesting and wait until every result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    // Register write; cfg_we stays high until end_writes
    task automatic write_reg(input logic [tbr_pkg::CFG_IDX_BITS-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[COORD_BITS-1:0];
        @(posedge clk);
        if (idx < tbr_pkg::NUM_REGS)
            vtx[idx] = value[COORD_BITS-1:0];
    endtask

    task automatic end_writes();
        cfg_we <= 1'b0;
        phase_count++;
    endtask

    task automatic set_triangle(input int ax, input int ay, input int bx, input int by,
                                input int cx, input int cy);
        wait_drained();
        write_reg(tbr_pkg::REG_A_X, ax);
        write_reg(tbr_pkg::REG_A_Y, ay);
        write_reg(tbr_pkg::REG_B_X, bx);
        write_reg(tbr_pkg::REG_B_Y, by);
        write_reg(tbr_pkg::REG_C_X, cx);
        write_reg(tbr_pkg::REG_C_Y, cy);
        end_writes();
    endtask

    function automatic int clamp_coord(input int v);
        if (v < -2048)
            return -2048;
        if (v > 2047)
            return 2047;
        return v;
    endfunction

    // Reset vertices are all zero: a one-point box of zero area
    task automatic test_after_reset();
        gaps_on = 1'b0;
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
    endtask

    // Full-range vertices, both windings; the walk keeps its position
    task automatic test_extreme_vertices();
        gaps_on = 1'b1;
        set_triangle(-2048, -2048, 2047, -2048, -2048, 2047);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        set_triangle(-2048, -2048, -2048, 2047, 2047, -2048);
        send_request(1'b0);
        send_request(1'b0);
    endtask

    // Flat column at max x: box changes under the walk, end flag at the top corner
    task automatic test_edge_column();
        set_triangle(2047, 2044, 2047, 2047, 2047, 2045);
        repeat (5) send_request(1'b0);
    endtask

    // Small triangle walked to the end and wrapped back to the corner
    task automatic test_small_wrap();
        set_triangle(0, 0, 2, 0, 0, 2);
        repeat (10) send_request(1'b0);
    endtask

    // Writes past the register file leave the vertices alone
    task automatic test_spare_index();
        wait_drained();
        write_reg(SPARE_INDEX_LO, $urandom_range(0, 4095));
        write_reg(SPARE_INDEX_HI, $urandom_range(0, 4095));
        end_writes();
        send_request(1'b0);
        send_request(1'b0);
    endtask

    // Random triangles: mostly small boxes that wrap, some full-range ones
    task automatic test_random_triangles();
        int coord [tbr_pkg::NUM_REGS];
        int target, base_x, base_y, spread, n_items, first;
        bit wide;
        target = sent_count + RANDOM_ITEMS;
        while (sent_count < target)
        begin
            wait_drained();
            wide   = ($urandom_range(0, 9) == 0);
            base_x = $urandom_range(0, 4095) - 2048;
            base_y = $urandom_range(0, 4095) - 2048;
            spread = $urandom_range(0, 6);
            for (int i = 0; i < tbr_pkg::NUM_REGS; i++)
            begin
                if (wide)
                    coord[i] = $urandom_range(0, 4095) - 2048;
                else
                    coord[i] = clamp_coord(((i % 2 == 0) ? base_x : base_y) +
                                           $urandom_range(0, spread));
            end
            // Degenerate: third vertex on top of the first
            if ($urandom_range(0, 7) == 0)
            begin
                coord[tbr_pkg::REG_C_X] = coord[tbr_pkg::REG_A_X];
                coord[tbr_pkg::REG_C_Y] = coord[tbr_pkg::REG_A_Y];
            end
            first = $urandom_range(0, tbr_pkg::NUM_REGS - 1);
            for (int k = 0; k < tbr_pkg::NUM_REGS; k++)
            begin
                if ($urandom_range(0, 3) != 0)
                    write_reg(tbr_pkg::CFG_IDX_BITS'((first + k) % tbr_pkg::NUM_REGS),
                              coord[(first + k) % tbr_pkg::NUM_REGS]);
            end
            if ($urandom_range(0, 5) == 0)
                write_reg($urandom_range(0, 1) ? SPARE_INDEX_HI : SPARE_INDEX_LO,
                          $urandom_range(0, 4095));
            end_writes();

            gaps_on = ($urandom_range(0, 3) != 0);
            n_items = wide ? $urandom_range(3, 12) : $urandom_range(5, 60);
            repeat (n_items)
                send_request($urandom_range(0, 19) == 0);
        end
    endtask

    // Receiver: random stall mode, redrawn each time its hold counter runs out
    always @(posedge clk)
    begin
        if (stall_hold == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 2));
            stall_hold = $urandom_range(20, 120);
        end
        stall_hold--;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            default:     out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Result check against the oldest pending prediction
    always @(posedge clk)
    begin : check_result
        pixel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected result at (%0d,%0d)", pixel_x, pixel_y);
                fail_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (pixel_x !== want.x)
                begin
                    $error("pixel_x: expected %0d, got %0d", want.x, pixel_x);
                    fail_count++;
                end
                if (pixel_y !== want.y)
                begin
                    $error("pixel_y: expected %0d, got %0d", want.y, pixel_y);
                    fail_count++;
                end
                if (covered !== want.covered)
                begin
                    $error("covered: expected %0b, got %0b at (%0d,%0d)",
                           want.covered, covered, want.x, want.y);
                    fail_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0b, got %0b at (%0d,%0d)",
                           want.last, last, want.x, want.y);
                    fail_count++;
                end
                checked_count++;
                covered_seen += want.covered;
                last_seen    += want.last;
            end
        end
    end

    // Run limit
    initial
    begin
        #1_000_000;
        $display("triangle_bbox_rasterizer_core test failed");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < tbr_pkg::NUM_REGS; i++)
            vtx[i] = '0;
        walk_x = 0;
        walk_y = 0;
        walk_at_start = 1'b1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_extreme_vertices();
        test_edge_column();
        test_small_wrap();
        test_spare_index();
        test_random_triangles();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Walked %0d box positions over %0d vertex setups (%0d restarts).",
                 checked_count, phase_count, restart_count);
        $display("Saw %0d covered positions and %0d box-end markers.",
                 covered_seen, last_seen);
        if (fail_count == 0)
            $display("triangle_bbox_rasterizer_core test passed");
        else
            $display("triangle_bbox_rasterizer_core test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tbr_pkg.sv
hw/rtl/tbr_coverage.sv
hw/rtl/triangle_bbox_rasterizer_core.sv
bench/testbench.sv
